[rtl/core/assert_macros.svh]
// Assertion macros shared by the bit packer modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/hcbp_pkg.sv]
// Package for the Huffman code bit packer: item kinds, controller states,
// command and status structs and fixed widths. No dependencies.
package hcbp_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned TOTAL_W = 32;
  // Accumulator: up to seven pending bits plus one full code
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned FILL_W  = 6;

  // Kind of an input item, carried in tuser
  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FINISH = 2'd2
  } kind_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EMIT,
    ST_FLUSH_BYTE,
    ST_FLUSH_COUNT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic mem_wr;
    logic mem_rd;
    logic merge;
    logic emit_byte;
    logic byte_last;
    logic emit_count;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cnt_nz;
    logic cnt_ge8;
    logic cnt_ge16;
    logic out_free;
  } status_t;

endpackage

[rtl/core/hcbp_datapath.sv]
// Datapath of the Huffman code bit packer: code table memory, bit
// accumulator, bit total counter and output register. Uses hcbp_pkg.
`include "assert_macros.svh"

module hcbp_datapath #(
  parameter int unsigned SYMBOLS        = 256,
  parameter int unsigned CODE_LEN_LIMIT = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hcbp_pkg::cmd_t                    cmd,
  output hcbp_pkg::status_t                 sts,
  input  logic [hcbp_pkg::BYTE_W-1:0]       symbol,
  input  logic [hcbp_pkg::CODE_W-1:0]       code_bits,
  input  logic [hcbp_pkg::LEN_W-1:0]        code_length,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [hcbp_pkg::BYTE_W-1:0]       out_byte,
  output logic                              out_is_count,
  output logic [hcbp_pkg::TOTAL_W-1:0]      out_total,
  output logic                              out_last
);

  localparam int unsigned AW    = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int unsigned CAP   = (CODE_LEN_LIMIT < 32) ? CODE_LEN_LIMIT : 32;
  localparam int unsigned ENT_W = hcbp_pkg::LEN_W + hcbp_pkg::CODE_W;

  logic [ENT_W-1:0]                   code_mem [SYMBOLS];
  logic [ENT_W-1:0]                   rd_entry;
  logic                               rd_ok;
  logic                               sym_ok;
  logic [AW-1:0]                      addr;
  logic [hcbp_pkg::LEN_W-1:0]         len_wr;
  logic [hcbp_pkg::LEN_W-1:0]         len_rd;
  logic [hcbp_pkg::LEN_W-1:0]         len_eff;
  logic [hcbp_pkg::CODE_W-1:0]        code_masked;
  logic [hcbp_pkg::LEN_W-1:0]         shift_amt;
  logic [hcbp_pkg::ACC_W-1:0]         placed;
  logic [hcbp_pkg::ACC_W-1:0]         acc;
  logic [hcbp_pkg::FILL_W-1:0]        cnt;
  logic [hcbp_pkg::TOTAL_W-1:0]       total;
  logic [hcbp_pkg::TOTAL_W:0]         total_sum;

  // Address check and length clamp for table writes
  assign sym_ok = ({1'b0, symbol} < 9'(SYMBOLS));
  assign addr   = symbol[AW-1:0];
  assign len_wr = (code_length > hcbp_pkg::LEN_W'(CAP)) ? hcbp_pkg::LEN_W'(CAP) : code_length;

  // Code table memory, written and read in the cycle the item is accepted
  always_ff @(posedge clk) begin
    if (cmd.mem_wr && sym_ok) begin
      code_mem[addr] <= {len_wr, code_bits};
    end
    if (cmd.mem_rd) begin
      rd_entry <= code_mem[addr];
      rd_ok    <= sym_ok;
    end
  end

  // Effective length and the code bits placed just below the pending bits
  assign len_rd      = rd_entry[ENT_W-1 -: hcbp_pkg::LEN_W];
  assign len_eff     = !rd_ok ? '0 :
                       (len_rd > hcbp_pkg::LEN_W'(CAP)) ? hcbp_pkg::LEN_W'(CAP) : len_rd;
  assign code_masked = rd_entry[hcbp_pkg::CODE_W-1:0] & ~({hcbp_pkg::CODE_W{1'b1}} << len_eff);
  assign shift_amt   = hcbp_pkg::LEN_W'(hcbp_pkg::ACC_W) - cnt - len_eff;
  assign placed      = {{(hcbp_pkg::ACC_W-hcbp_pkg::CODE_W){1'b0}}, code_masked} << shift_amt;
  assign total_sum   = {1'b0, total} + (hcbp_pkg::TOTAL_W+1)'(len_eff);

  // Accumulator, pending bit count and saturating bit total
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      cnt   <= '0;
      total <= '0;
    end else if (cmd.emit_count) begin
      acc   <= '0;
      cnt   <= '0;
      total <= '0;
    end else if (cmd.merge) begin
      acc   <= acc | placed;
      cnt   <= cnt + len_eff;
      total <= total_sum[hcbp_pkg::TOTAL_W] ? '1 : total_sum[hcbp_pkg::TOTAL_W-1:0];
    end else if (cmd.emit_byte) begin
      acc <= acc << hcbp_pkg::BYTE_W;
      cnt <= sts.cnt_ge8 ? (cnt - hcbp_pkg::FILL_W'(hcbp_pkg::BYTE_W)) : '0;
    end
  end

  // Status towards the controller
  assign sts.cnt_nz   = (cnt != '0);
  assign sts.cnt_ge8  = (cnt >= hcbp_pkg::FILL_W'(8));
  assign sts.cnt_ge16 = (cnt >= hcbp_pkg::FILL_W'(16));
  assign sts.out_free = !m_tvalid || m_tready;

  // Output register: holds a result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_byte || cmd.emit_count) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      out_byte     <= acc[hcbp_pkg::ACC_W-1 -: hcbp_pkg::BYTE_W];
      out_is_count <= 1'b0;
      out_total    <= '0;
      out_last     <= cmd.byte_last;
    end else if (cmd.emit_count) begin
      out_byte     <= '0;
      out_is_count <= 1'b1;
      out_total    <= total;
      out_last     <= 1'b1;
    end
  end

  // A count result is always the last of its run.
  `HCBP_ASSERT_NEXT(a_count_last, cmd.emit_count, m_tvalid && out_is_count && out_last,
    "count result not marked last")
  // A new result is only loaded when the output register is free.
  `HCBP_ASSERT_IMPL(a_emit_free, cmd.emit_byte || cmd.emit_count, sts.out_free,
    "result overwrites one not yet transferred")

endmodule

[rtl/core/hcbp_ctrl.sv]
// Controller state machine of the Huffman code bit packer: sequences load,
// encode and finish items and issues commands to the datapath. Uses hcbp_pkg.
`include "assert_macros.svh"

module hcbp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [1:0]          s_kind,
  input  hcbp_pkg::status_t   sts,
  output hcbp_pkg::cmd_t      cmd
);

  hcbp_pkg::state_t state;
  hcbp_pkg::state_t state_next;
  hcbp_pkg::kind_t  kind;
  logic             accept;

  assign kind   = hcbp_pkg::kind_t'(s_kind);
  assign accept = (state == hcbp_pkg::ST_IDLE) && s_tvalid;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hcbp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      hcbp_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          case (kind)
            hcbp_pkg::KIND_ENCODE: state_next = hcbp_pkg::ST_MERGE;
            hcbp_pkg::KIND_FINISH: state_next = hcbp_pkg::ST_FLUSH_BYTE;
            default:               state_next = hcbp_pkg::ST_IDLE;
          endcase
        end
      end
      hcbp_pkg::ST_MERGE: begin
        state_next = hcbp_pkg::ST_EMIT;
      end
      hcbp_pkg::ST_EMIT: begin
        if (!sts.cnt_ge8) begin
          state_next = hcbp_pkg::ST_IDLE;
        end else if (sts.out_free && !sts.cnt_ge16) begin
          state_next = hcbp_pkg::ST_IDLE;
        end
      end
      hcbp_pkg::ST_FLUSH_BYTE: begin
        if (!sts.cnt_nz || sts.out_free) begin
          state_next = hcbp_pkg::ST_FLUSH_COUNT;
        end
      end
      hcbp_pkg::ST_FLUSH_COUNT: begin
        if (sts.out_free) begin
          state_next = hcbp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hcbp_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    s_tready       = (state == hcbp_pkg::ST_IDLE);
    cmd            = '0;
    cmd.mem_wr     = accept && (kind == hcbp_pkg::KIND_LOAD);
    cmd.mem_rd     = accept && (kind == hcbp_pkg::KIND_ENCODE);
    case (state)
      hcbp_pkg::ST_MERGE: begin
        cmd.merge = 1'b1;
      end
      hcbp_pkg::ST_EMIT: begin
        cmd.emit_byte = sts.cnt_ge8 && sts.out_free;
        cmd.byte_last = !sts.cnt_ge16;
      end
      hcbp_pkg::ST_FLUSH_BYTE: begin
        cmd.emit_byte = sts.cnt_nz && sts.out_free;
        cmd.byte_last = 1'b0;
      end
      hcbp_pkg::ST_FLUSH_COUNT: begin
        cmd.emit_count = sts.out_free;
      end
      default: begin
        cmd.merge = 1'b0;
      end
    endcase
  end

  // A full byte never waits in the buffer while the block is idle.
  `HCBP_ASSERT_IMPL(a_idle_no_full_byte, state == hcbp_pkg::ST_IDLE, !sts.cnt_ge8,
    "full byte left pending in idle")
  // A finish leaves the buffer empty and the block idle.
  `HCBP_ASSERT_NEXT(a_finish_clears, cmd.emit_count,
    state == hcbp_pkg::ST_IDLE && !sts.cnt_nz, "finish did not clear the buffer")
  // A table read is only issued for an encode item being taken.
  `HCBP_ASSERT_NEXT(a_read_then_merge, cmd.mem_rd, state == hcbp_pkg::ST_MERGE,
    "table read not followed by merge")

endmodule

[rtl/core/huffman_code_bit_packer.sv]
// Huffman code bit packer: slave stream of load, encode and finish items,
// master stream of packed bytes and bit totals.
// Depends on hcbp_pkg, hcbp_ctrl and hcbp_datapath.
//
// Use: send load items (tuser = 0) to fill the code table, then encode items
// (tuser = 1) with one symbol each, then a finish item (tuser = 2). Each
// encode transfer produces zero to four bytes, first code bit in bit 7; a
// finish produces the padded partial byte, if any, and then the bit total
// (m_tuser high). m_tlast marks the final result caused by an input item.
// Timing: one item is worked on at a time. A load is written to the table
// as it is accepted. An encode goes through the registered table read, the
// merge of the code into the accumulator, which then holds up to 39 bits,
// and one byte leaving the accumulator per cycle while the output register
// is free. A finish passes the byte flush and count flush states.
// Reset clears the buffer, the pending bit count and the total; the code table
// is not cleared and must be loaded before use. When the receiver stalls, the
// result is held in the output register and the controller waits with it;
// s_tready stays low until the item is complete.

module huffman_code_bit_packer #(
  parameter int unsigned SYMBOLS        = 256,
  parameter int unsigned CODE_LEN_LIMIT = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // symbol[7:0], code_bits[39:8], code_length[45:40], zeros
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_byte[7:0], bit_total[39:8]
  output logic [0:0]  m_tuser,   // is_count[0]
  output logic        m_tlast    // last_of_run
);

  hcbp_pkg::cmd_t                cmd;
  hcbp_pkg::status_t             sts;
  logic [hcbp_pkg::BYTE_W-1:0]   out_byte;
  logic                          out_is_count;
  logic [hcbp_pkg::TOTAL_W-1:0]  out_total;
  logic                          out_last;

  // Sequencer
  hcbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_kind   (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table, accumulator and output register
  hcbp_datapath #(
    .SYMBOLS        (SYMBOLS),
    .CODE_LEN_LIMIT (CODE_LEN_LIMIT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .symbol       (s_tdata[7:0]),
    .code_bits    (s_tdata[39:8]),
    .code_length  (s_tdata[45:40]),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .out_byte     (out_byte),
    .out_is_count (out_is_count),
    .out_total    (out_total),
    .out_last     (out_last)
  );

  // Output packing
  assign m_tdata    = {out_total, out_byte};
  assign m_tuser[0] = out_is_count;
  assign m_tlast    = out_last;

endmodule
